// File: hdl/lpcp_pkg.sv
// lpcp_pkg: shared widths, register indexes, reset values and helpers
// for the lidar point camera projection block; no dependencies
package lpcp_pkg;

	localparam int PIX_W   = 12;
	localparam int PT_W    = 20;
	localparam int COEF_W  = 16;
	localparam int FRAC_W  = 14;
	localparam int PROD_W  = PT_W + COEF_W;
	localparam int CAM_W   = PROD_W + 2;
	localparam int NUM_W   = CAM_W + COEF_W + 1;
	localparam int REM_W   = NUM_W - 1;
	localparam int DEN_W   = CAM_W - 1 + 4;
	localparam int DIV_LAT = PIX_W + 1;
	localparam int CFG_W   = 64;
	localparam int IDX_W   = 3;

	localparam int IN_TDATA_W  = ((3 * PT_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((2 * PIX_W + 1 + 7) / 8) * 8;

	localparam logic [IDX_W-1:0] REG_ROW_X      = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROW_Y      = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROW_Z      = 3'd2;
	localparam logic [IDX_W-1:0] REG_INTRINSICS = 3'd3;
	localparam logic [IDX_W-1:0] REG_IMG_WIDTH  = 3'd4;
	localparam logic [IDX_W-1:0] REG_IMG_HEIGHT = 3'd5;

	localparam logic [CFG_W-1:0] ROW_X_RST = 64'd16384;
	localparam logic [CFG_W-1:0] ROW_Y_RST = 64'd1073741824;
	localparam logic [CFG_W-1:0] ROW_Z_RST = 64'd70368744177664;

	typedef struct packed {
		logic             in_img;
		logic [PIX_W-1:0] row;
		logic [PIX_W-1:0] col;
	} result_t;

	// signed 16-bit field number idx of a packed transform row
	function automatic logic signed [COEF_W-1:0] coef(input logic [CFG_W-1:0] word,
		input int idx);
		coef = $signed(word[idx*COEF_W +: COEF_W]);
	endfunction

endpackage

// File: hdl/lidar_point_camera_projection_top.sv
// lidar_point_camera_projection_top: rigid transform and pinhole projection
// of lidar points to pixel coordinates; depends on lpcp_pkg and lpcp_div
//
// usage:
// - s_* stream carries one lidar point per transaction (x, y, z signed mm)
// - m_* stream returns one result per point: column, row and inside flag
// - cfg_we/cfg_index/cfg_data write the transform, intrinsics and image size;
//   write them only while no point is in flight
// - throughput: one point per clock while s_tready stays high
// - datapath: 3 product/sum stages, 1 numerator stage, a 13-stage divider
//   (overflow check plus one quotient bit per stage), a bounds check stage
//   and the output register
// - a one-entry skid buffer behind the output register takes the result in
//   flight when m_tready drops; the pipeline then holds and s_tready falls
// - reset clears all valid bits and loads an identity rotation, zero
//   translation, zero intrinsics and a zero image size
module lidar_point_camera_projection_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [lpcp_pkg::IN_TDATA_W-1:0]      s_tdata,  // point_x, point_y, point_z
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [lpcp_pkg::OUT_TDATA_W-1:0]     m_tdata,  // pixel_col, pixel_row, inside_res
	input  logic                                 cfg_we,
	input  logic [lpcp_pkg::IDX_W-1:0]           cfg_index,
	input  logic [lpcp_pkg::CFG_W-1:0]           cfg_data
);

	logic [lpcp_pkg::CFG_W-1:0] row_q [0:2];
	logic [lpcp_pkg::CFG_W-1:0] intr_q;
	logic [lpcp_pkg::PIX_W-1:0] img_w_q;
	logic [lpcp_pkg::PIX_W-1:0] img_h_q;

	logic en;
	logic signed [lpcp_pkg::PT_W-1:0] pt [0:2];

	logic                               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [lpcp_pkg::PROD_W-1:0] prod_s1 [0:8];
	logic signed [lpcp_pkg::CAM_W-1:0]  cam_s2  [0:2];
	logic signed [lpcp_pkg::NUM_W-1:0]  mul_s3  [0:1];
	logic signed [lpcp_pkg::NUM_W-1:0]  off_s3  [0:1];
	logic signed [lpcp_pkg::CAM_W-1:0]  zc_s3;
	logic signed [lpcp_pkg::NUM_W-1:0]  num_s4  [0:1];
	logic        [lpcp_pkg::DEN_W-1:0]  den_s4;
	logic                               zpos_s4;
	logic                               vd_s    [0:lpcp_pkg::DIV_LAT-1];
	logic        [lpcp_pkg::PIX_W-1:0]  quo     [0:1];
	logic                               div_ok  [0:1];
	logic                               in_img;
	lpcp_pkg::result_t                  res_s5;

	lpcp_pkg::result_t out_q, skid_q;
	logic              out_v_q, skid_v_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= lpcp_pkg::ROW_X_RST;
			row_q[1] <= lpcp_pkg::ROW_Y_RST;
			row_q[2] <= lpcp_pkg::ROW_Z_RST;
			intr_q   <= '0;
			img_w_q  <= '0;
			img_h_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lpcp_pkg::REG_ROW_X:      row_q[0] <= cfg_data;
				lpcp_pkg::REG_ROW_Y:      row_q[1] <= cfg_data;
				lpcp_pkg::REG_ROW_Z:      row_q[2] <= cfg_data;
				lpcp_pkg::REG_INTRINSICS: intr_q   <= cfg_data;
				lpcp_pkg::REG_IMG_WIDTH:  img_w_q  <= cfg_data[lpcp_pkg::PIX_W-1:0];
				lpcp_pkg::REG_IMG_HEIGHT: img_h_q  <= cfg_data[lpcp_pkg::PIX_W-1:0];
				default: ;
			endcase
		end
	end

	assign en       = !skid_v_q;
	assign s_tready = en;

	for (genvar c = 0; c < 3; c++) begin : g_pt
		assign pt[c] = $signed(s_tdata[c*lpcp_pkg::PT_W +: lpcp_pkg::PT_W]);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int i = 0; i < lpcp_pkg::DIV_LAT; i++) begin
				vd_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1    <= s_tvalid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			vd_s[0] <= v_s4;
			for (int i = 1; i < lpcp_pkg::DIV_LAT; i++) begin
				vd_s[i] <= vd_s[i-1];
			end
			v_s5 <= vd_s[lpcp_pkg::DIV_LAT-1];
		end
	end

	// rotation products, camera coordinates, projection products, numerators
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r*3+c] <= lpcp_pkg::coef(row_q[r], c) * pt[c];
				end
			end
			for (int r = 0; r < 3; r++) begin
				cam_s2[r] <= lpcp_pkg::CAM_W'(prod_s1[r*3])
					+ lpcp_pkg::CAM_W'(prod_s1[r*3+1])
					+ lpcp_pkg::CAM_W'(prod_s1[r*3+2])
					+ (lpcp_pkg::CAM_W'(lpcp_pkg::coef(row_q[r], 3)) <<< lpcp_pkg::FRAC_W);
			end
			for (int i = 0; i < 2; i++) begin
				mul_s3[i] <= lpcp_pkg::NUM_W'(cam_s2[i])
					* lpcp_pkg::NUM_W'($signed({1'b0, intr_q[i*16 +: 16]}));
				off_s3[i] <= lpcp_pkg::NUM_W'(cam_s2[2])
					* lpcp_pkg::NUM_W'($signed({1'b0, intr_q[32+i*16 +: 16]}));
			end
			zc_s3 <= cam_s2[2];
			for (int i = 0; i < 2; i++) begin
				num_s4[i] <= mul_s3[i] + off_s3[i];
			end
			den_s4  <= {zc_s3[lpcp_pkg::DEN_W-5:0], 4'b0000};
			zpos_s4 <= !zc_s3[lpcp_pkg::CAM_W-1] && (|zc_s3);
		end
	end

	for (genvar i = 0; i < 2; i++) begin : g_div
		lpcp_div u_div (
			.clk     (clk),
			.en      (en),
			.num     (num_s4[i]),
			.den     (den_s4),
			.den_pos (zpos_s4),
			.quo     (quo[i]),
			.ok      (div_ok[i])
		);
	end

	// image bounds
	assign in_img = div_ok[0] && div_ok[1] && (|quo[0]) && (|quo[1])
		&& (quo[0] < img_w_q) && (quo[1] < img_h_q);

	always_ff @(posedge clk) begin
		if (en) begin
			res_s5.in_img <= in_img;
			res_s5.col    <= in_img ? quo[0] : '0;
			res_s5.row    <= in_img ? quo[1] : '0;
		end
	end

	// output register and skid buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= v_s5;
			end
		end else if (v_s5) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			out_q <= skid_v_q ? skid_q : res_s5;
		end else if (en) begin
			skid_q <= res_s5;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = lpcp_pkg::OUT_TDATA_W'(out_q);

endmodule

// File: hdl/lpcp_div.sv
// lpcp_div: pipelined restoring divider, one quotient bit per stage
// depends on lpcp_pkg; quotient is floor(num/den), meaningful only when ok
module lpcp_div (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [lpcp_pkg::NUM_W-1:0]    num,
	input  logic        [lpcp_pkg::DEN_W-1:0]    den,
	input  logic                                 den_pos,
	output logic        [lpcp_pkg::PIX_W-1:0]    quo,
	output logic                                 ok
);

	logic [lpcp_pkg::REM_W-1:0] rem_s [0:lpcp_pkg::PIX_W-1];
	logic [lpcp_pkg::DEN_W-1:0] den_s [0:lpcp_pkg::PIX_W-1];
	logic [lpcp_pkg::PIX_W-1:0] q_s   [0:lpcp_pkg::PIX_W];
	logic                       ok_s  [0:lpcp_pkg::PIX_W];

	logic num_pos;
	logic ovf;

	assign num_pos = !num[lpcp_pkg::NUM_W-1] && (|num);
	assign ovf = num[lpcp_pkg::REM_W-1:0] >=
		(lpcp_pkg::REM_W'(den) << lpcp_pkg::PIX_W);

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s[0]  <= den_pos && num_pos && !ovf;
			rem_s[0] <= (den_pos && num_pos && !ovf) ? num[lpcp_pkg::REM_W-1:0] : '0;
			den_s[0] <= den;
			q_s[0]   <= '0;
		end
	end

	for (genvar g = 0; g < lpcp_pkg::PIX_W; g++) begin : g_stage
		logic [lpcp_pkg::REM_W-1:0] sub;
		logic                       ge;

		assign sub = lpcp_pkg::REM_W'(den_s[g]) << (lpcp_pkg::PIX_W - 1 - g);
		assign ge  = rem_s[g] >= sub;

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[g+1]  <= {q_s[g][lpcp_pkg::PIX_W-2:0], ge};
				ok_s[g+1] <= ok_s[g];
			end
		end

		if (g < lpcp_pkg::PIX_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g+1] <= ge ? rem_s[g] - sub : rem_s[g];
					den_s[g+1] <= den_s[g];
				end
			end
		end
	end

	assign quo = q_s[lpcp_pkg::PIX_W];
	assign ok  = ok_s[lpcp_pkg::PIX_W];

endmodule
